@@ rtl/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int CURSOR_W    = 11;
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [7:0] ATTR_RESET   = 8'h0F;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_BLANK   = 8'h20;

    // command codes
    localparam logic [1:0] CMD_TYPE      = 2'd0;
    localparam logic [1:0] CMD_BACKSPACE = 2'd1;
    localparam logic [1:0] CMD_CLEAR     = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
    } t_cmd_word;

    typedef struct packed {
        logic                cell_write;
        logic [CURSOR_W-1:0] cell_addr;
        logic [15:0]         cell_value;
        logic                clear_screen;
        logic [CURSOR_W-1:0] cursor_pos;
        logic [7:0]          cursor_low_byte;
        logic [2:0]          cursor_high_byte;
    } t_res_word;

endpackage

@@ rtl/tcce_step.sv @@
// ----------------------------------------------------------------------------
// tcce_step
// Next cursor, column and cell write for one command word.
// ----------------------------------------------------------------------------
module tcce_step #(
    parameter int SCREEN_COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int SCREEN_ROWS    = tcce_pkg::DEF_ROWS,
    localparam int COL_W         = $clog2(SCREEN_COLUMNS)
) (
    input  tcce_pkg::t_cmd_word                i_word,
    input  logic [tcce_pkg::CURSOR_W-1:0]      i_cursor,
    input  logic [COL_W-1:0]                   i_col,
    input  logic [7:0]                         i_attr,
    output tcce_pkg::t_res_word                o_res,
    output logic [tcce_pkg::CURSOR_W-1:0]      o_cursor,
    output logic [COL_W-1:0]                   o_col
);
    import tcce_pkg::*;

    localparam int TOTAL = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int SUM_W = CURSOR_W + 1;
    localparam logic [COL_W:0]   COLS_X  = (COL_W+1)'(SCREEN_COLUMNS);
    localparam logic [COL_W-1:0] COLS_M1 = COL_W'(SCREEN_COLUMNS - 1);

    logic [SUM_W-1:0] cur_x;
    logic [SUM_W-1:0] sum;
    logic [COL_W:0]   col_gap;
    logic [COL_W:0]   col_tab;
    logic [2:0]       tab_inc;
    logic [COL_W-1:0] col_typed;
    logic             ovf;

    always_comb begin
        cur_x     = {1'b0, i_cursor};
        tab_inc   = 3'd4 - {1'b0, i_cursor[1:0]};
        col_gap   = COLS_X - {1'b0, i_col};
        col_tab   = {1'b0, i_col} + (COL_W+1)'(tab_inc);
        sum       = cur_x + SUM_W'(1);
        col_typed = (i_col == COLS_M1) ? '0 : i_col + COL_W'(1);
        if (i_word.char_code == CHAR_NEWLINE) begin
            sum       = cur_x + SUM_W'(col_gap);
            col_typed = '0;
        end else if (i_word.char_code == CHAR_TAB) begin
            sum       = cur_x + SUM_W'(tab_inc);
            col_typed = (col_tab >= COLS_X) ? COL_W'(col_tab - COLS_X) : col_tab[COL_W-1:0];
        end
        ovf = (32'(sum) >= TOTAL);

        o_res    = '0;
        o_cursor = i_cursor;
        o_col    = i_col;
        case (i_word.cmd)
            CMD_TYPE: begin
                if (i_word.char_code != CHAR_NEWLINE && i_word.char_code != CHAR_TAB) begin
                    o_res.cell_write = 1'b1;
                    o_res.cell_addr  = i_cursor;
                    o_res.cell_value = {i_attr, i_word.char_code};
                end
                if (ovf) begin
                    o_res.clear_screen = 1'b1;
                    o_cursor = '0;
                    o_col    = '0;
                end else if (sum[SUM_W-1]) begin
                    // wrapped past the cursor width: what is left is below one line
                    o_cursor = sum[CURSOR_W-1:0];
                    o_col    = sum[COL_W-1:0];
                end else begin
                    o_cursor = sum[CURSOR_W-1:0];
                    o_col    = col_typed;
                end
            end
            CMD_BACKSPACE: begin
                if (i_cursor != '0) begin
                    o_cursor         = i_cursor - CURSOR_W'(1);
                    o_col            = (i_col == '0) ? COLS_M1 : i_col - COL_W'(1);
                    o_res.cell_write = 1'b1;
                    o_res.cell_addr  = i_cursor - CURSOR_W'(1);
                    o_res.cell_value = {i_attr, CHAR_BLANK};
                end
            end
            CMD_CLEAR: begin
                o_res.clear_screen = 1'b1;
            end
            default: begin
            end
        endcase
        o_res.cursor_pos       = o_cursor;
        o_res.cursor_low_byte  = o_cursor[7:0];
        o_res.cursor_high_byte = o_cursor[CURSOR_W-1:8];
    end

endmodule

@@ rtl/text_console_cursor_engine.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Cursor tracking and cell writes for a text-mode console.
//
//   channel   signals                          moves
//   input     i_in_valid / o_in_ready          t_cmd_word (cmd, char_code)
//   output    o_out_valid / i_out_ready        t_res_word (cell write, cursor)
//   config    i_cfg_wr_en / i_cfg_data         text attribute byte
//
// One word per cycle while the output is not stalled: a word is captured in the
// input register, the cursor update runs in the logic after it, and the result is
// held in the output register.
// The column is kept as a register next to the cursor, so no divider is used.
// Reset clears cursor, column and valid flags and loads attribute 0x0F.
// A stall on the output holds both registers; the input still takes a word
// while the input register is empty.
// ----------------------------------------------------------------------------
module text_console_cursor_engine #(
    parameter int SCREEN_COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int SCREEN_ROWS    = tcce_pkg::DEF_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tcce_pkg::t_cmd_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tcce_pkg::t_res_word  o_out_word,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_data
);
    import tcce_pkg::*;

    localparam int COL_W = $clog2(SCREEN_COLUMNS);

    logic                r_in_vld;
    t_cmd_word           r_in_word;
    logic                r_out_vld;
    t_res_word           r_out_word;
    logic [CURSOR_W-1:0] r_cursor;
    logic [COL_W-1:0]    r_col;
    logic [7:0]          r_attr;

    t_res_word           n_res;
    logic [CURSOR_W-1:0] n_cursor;
    logic [COL_W-1:0]    n_col;
    logic                advance;

    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    tcce_step #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_ROWS   (SCREEN_ROWS)
    ) u_step (
        .i_word  (r_in_word),
        .i_cursor(r_cursor),
        .i_col   (r_col),
        .i_attr  (r_attr),
        .o_res   (n_res),
        .o_cursor(n_cursor),
        .o_col   (n_col)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cursor  <= '0;
            r_col     <= '0;
            r_attr    <= ATTR_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_cursor  <= n_cursor;
                r_col     <= n_col;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= n_res;
        end
    end

endmodule

@@ sim/tcce_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcce_checker
// Watches the command, result and attribute ports of the console cursor
// engine, predicts each result word from its own cursor and attribute copy
// and compares every accepted result word field by field, in order.
// ----------------------------------------------------------------------------
module tcce_checker #(
    parameter int SCREEN_COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int SCREEN_ROWS    = tcce_pkg::DEF_ROWS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  tcce_pkg::t_cmd_word i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  tcce_pkg::t_res_word i_out_word,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import tcce_pkg::*;

    localparam int SCREEN_CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int TAB_STEP     = 4;

    logic [CURSOR_W-1:0] cursor_copy;
    logic [7:0]          attr_copy;
    t_res_word           due_results[$];
    int                  mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
        cursor_copy  = '0;
        attr_copy    = ATTR_RESET;
    end

    // one command word -> the result word it must produce
    function automatic t_res_word console_step(logic [CURSOR_W-1:0] cur, logic [7:0] attr,
                                               t_cmd_word w);
        t_res_word r;
        int        c;
        int        n;
        r = '0;
        c = int'(cur);
        n = c;
        case (w.cmd)
            CMD_TYPE: begin
                if (w.char_code == CHAR_NEWLINE) begin
                    n = c + SCREEN_COLUMNS - (c % SCREEN_COLUMNS);
                end else if (w.char_code == CHAR_TAB) begin
                    n = c + TAB_STEP - (c % TAB_STEP);
                end else begin
                    r.cell_write = 1'b1;
                    r.cell_addr  = cur;
                    r.cell_value = {attr, w.char_code};
                    n            = c + 1;
                end
                // the cell write stays, the clear follows it
                if (n >= SCREEN_CELLS) begin
                    r.clear_screen = 1'b1;
                    n              = 0;
                end
            end
            CMD_BACKSPACE: begin
                if (c > 0) begin
                    n            = c - 1;
                    r.cell_write = 1'b1;
                    r.cell_addr  = CURSOR_W'(n);
                    r.cell_value = {attr, CHAR_BLANK};
                end
            end
            CMD_CLEAR: begin
                r.clear_screen = 1'b1;
            end
            default: begin
            end
        endcase
        r.cursor_pos       = CURSOR_W'(n);
        r.cursor_low_byte  = 8'(n);
        r.cursor_high_byte = 3'(n >> 8);
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        mismatches++;
        $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, field, got, want);
    endtask

    always @(posedge i_clk) begin
        t_res_word want;
        t_res_word got;
        if (!i_rst_n) begin
            cursor_copy = '0;
            attr_copy   = ATTR_RESET;
            due_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_word;
                if (due_results.size() == 0) begin
                    report_mismatch("result word with none due", int'(got.cursor_pos), 0);
                end else begin
                    want = due_results.pop_front();
                    if (got.cell_write !== want.cell_write)
                        report_mismatch("cell_write", int'(got.cell_write),
                                        int'(want.cell_write));
                    if (got.cell_addr !== want.cell_addr)
                        report_mismatch("cell_addr", int'(got.cell_addr),
                                        int'(want.cell_addr));
                    if (got.cell_value !== want.cell_value)
                        report_mismatch("cell_value", int'(got.cell_value),
                                        int'(want.cell_value));
                    if (got.clear_screen !== want.clear_screen)
                        report_mismatch("clear_screen", int'(got.clear_screen),
                                        int'(want.clear_screen));
                    if (got.cursor_pos !== want.cursor_pos)
                        report_mismatch("cursor_pos", int'(got.cursor_pos),
                                        int'(want.cursor_pos));
                    if (got.cursor_low_byte !== want.cursor_low_byte)
                        report_mismatch("cursor_low_byte", int'(got.cursor_low_byte),
                                        int'(want.cursor_low_byte));
                    if (got.cursor_high_byte !== want.cursor_high_byte)
                        report_mismatch("cursor_high_byte", int'(got.cursor_high_byte),
                                        int'(want.cursor_high_byte));
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = console_step(cursor_copy, attr_copy, i_in_word);
                cursor_copy = want.cursor_pos;
                due_results.push_back(want);
            end
            if (i_cfg_wr_en) begin
                attr_copy = i_cfg_data;
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= due_results.size();
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives command words into the console cursor engine: a directed opening,
// then mixed text, page-filling runs that force the wrap to the top, rewinds
// past zero and noise, under several attribute values and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
    import tcce_pkg::*;

    localparam int COLS         = DEF_COLUMNS;
    localparam int ROWS         = DEF_ROWS;
    localparam int CELLS        = COLS * ROWS;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 8;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       in_valid    = 1'b0;
    t_cmd_word  in_word     = '0;
    logic       out_ready   = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_data    = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_res_word  o_out_word;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    int send_idle    = 0;
    int recv_idle    = 0;
    int cmds_sent    = 0;
    int aim_cursor   = 0;

    text_console_cursor_engine #(
        .SCREEN_COLUMNS (COLS),
        .SCREEN_ROWS    (ROWS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_data  (cfg_data)
    );

    tcce_checker #(
        .SCREEN_COLUMNS (COLS),
        .SCREEN_ROWS    (ROWS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (o_out_word),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // rough cursor tracking, used to aim runs at the bottom of the page and to size rewinds past zero
    function automatic int advance_aim(int cur, t_cmd_word w);
        int n;
        n = cur;
        if (w.cmd == CMD_TYPE) begin
            if (w.char_code == CHAR_NEWLINE) n = cur + COLS - (cur % COLS);
            else if (w.char_code == CHAR_TAB) n = cur + 4 - (cur % 4);
            else n = cur + 1;
            if (n >= CELLS) n = 0;
        end else if (w.cmd == CMD_BACKSPACE && cur > 0) begin
            n = cur - 1;
        end
        return n;
    endfunction

    task automatic push_cmd(logic [1:0] cmd, logic [7:0] ch);
        t_cmd_word w;
        w.cmd       = cmd;
        w.char_code = ch;
        if ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        aim_cursor = advance_aim(aim_cursor, w);
        cmds_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_attribute(logic [7:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    // newlines down to the last row, tabs and text up to near its end, then text, a tab or a newline that may wrap
    task automatic fill_to_bottom();
        int target;
        while (aim_cursor / COLS < ROWS - 1) push_cmd(CMD_TYPE, CHAR_NEWLINE);
        target = CELLS - 1 - $urandom_range(0, 3);
        while (aim_cursor + 4 <= target) push_cmd(CMD_TYPE, CHAR_TAB);
        while (aim_cursor < target) push_cmd(CMD_TYPE, 8'($urandom_range(32, 126)));
        case ($urandom_range(0, 2))
            0: push_cmd(CMD_TYPE, 8'($urandom_range(0, 255)));
            1: push_cmd(CMD_TYPE, CHAR_TAB);
            default: push_cmd(CMD_TYPE, CHAR_NEWLINE);
        endcase
        // if that wrapped, a backspace right after it hits the cursor at zero
        if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 3)) push_cmd(CMD_BACKSPACE, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_mixed(int upto);
        int pick;
        int len;
        int r;
        while (cmds_sent < upto) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                len = $urandom_range(1, 30);
                repeat (len) begin
                    r = $urandom_range(0, 19);
                    if (r == 0) push_cmd(CMD_TYPE, CHAR_NEWLINE);
                    else if (r == 1) push_cmd(CMD_TYPE, CHAR_TAB);
                    else if (r == 2) push_cmd(CMD_BACKSPACE, 8'($urandom_range(0, 255)));
                    else push_cmd(CMD_TYPE, 8'($urandom_range(0, 255)));
                end
            end else if (pick < 68) begin
                fill_to_bottom();
            end else if (pick < 78) begin
                len = (aim_cursor <= 12) ? aim_cursor + $urandom_range(1, 3)
                                         : $urandom_range(1, 6);
                repeat (len) push_cmd(CMD_BACKSPACE, 8'($urandom_range(0, 255)));
            end else if (pick < 85) begin
                push_cmd(($urandom_range(0, 1) == 1) ? CMD_CLEAR : 2'($urandom_range(3, 3)),
                         8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    push_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening with the reset attribute, no idling
        push_cmd(CMD_BACKSPACE, 8'hFF);
        push_cmd(2'($urandom_range(3, 3)), 8'hAA);
        push_cmd(CMD_CLEAR, 8'h55);
        push_cmd(CMD_TYPE, 8'h00);
        push_cmd(CMD_TYPE, 8'hFF);
        push_cmd(CMD_TYPE, 8'h41);
        push_cmd(CMD_TYPE, CHAR_TAB);
        push_cmd(CMD_TYPE, CHAR_TAB);
        push_cmd(CMD_TYPE, 8'h78);
        push_cmd(CMD_TYPE, CHAR_TAB);
        push_cmd(CMD_TYPE, CHAR_NEWLINE);
        push_cmd(CMD_TYPE, CHAR_TAB);
        push_cmd(CMD_BACKSPACE, 8'h00);
        push_cmd(CMD_TYPE, CHAR_NEWLINE);
        push_cmd(CMD_CLEAR, 8'hFF);
        push_cmd(CMD_BACKSPACE, 8'h0A);
        push_cmd(2'($urandom_range(3, 3)), 8'h09);
        push_cmd(CMD_TYPE, CHAR_NEWLINE);
        push_cmd(CMD_TYPE, CHAR_TAB);
        push_cmd(CMD_TYPE, CHAR_BLANK);
        push_cmd(CMD_TYPE, 8'h7F);
        push_cmd(CMD_BACKSPACE, 8'h80);

        set_attribute(8'hFF);
        send_idle = 33;
        recv_idle <= 71;
        run_mixed(500);

        set_attribute(8'h00);
        send_idle = 71;
        recv_idle <= 33;
        run_mixed(980);

        set_attribute(8'($urandom_range(0, 255)));
        send_idle = 0;
        recv_idle <= 0;
        run_mixed(1220);

        set_attribute(8'($urandom_range(0, 255)));
        run_mixed(1450);

        wait_idle();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ text_console_cursor_engine.f @@
rtl/tcce_pkg.sv
rtl/tcce_step.sv
rtl/text_console_cursor_engine.sv
sim/tcce_checker.sv
sim/testbench.sv
